FILE: sv/bti_pkg.sv
// Package for the bilinear table interpolator: transaction types, codes,
// fixed arithmetic constants and the reset chart. No dependencies.
`timescale 1ns / 1ps

package bti_pkg;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_LOAD  = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_LOADED = 2'd2;

   localparam int ALT_STEP  = 2000;
   localparam int TEMP_STEP = 20;
   localparam int TEMP_BASE = -20;

   localparam int ALT_W   = 14;
   localparam int TEMP_W  = 8;
   localparam int INDEX_W = 5;
   localparam int EVAL_W  = 12;
   localparam int VALUE_W = 16;
   localparam int CELL_W  = 4;
   localparam int FA_W    = 11;
   localparam int FT_W    = 5;

   // row = alt / 2000 and col = tmp / 20 by reciprocal multiply
   localparam int ROW_RECIP = 33555;
   localparam int ROW_SHIFT = 26;
   localparam int COL_RECIP = 205;
   localparam int COL_SHIFT = 12;

   // num / 2500 rounded: bias, saturation bound, then (n >> 2) / 625
   localparam int           ROUND_BIAS = 1250;
   localparam logic [63:0]  SAT_LIMIT  = 64'd81920000;
   localparam int           QIN_W      = 25;
   localparam logic [25:0]  QDIV_RECIP = 26'd54975582;
   localparam int           QDIV_SHIFT = 35;
   localparam int           PROD_W     = 51;
   localparam int           QOUT_W     = 15;

   localparam int CHART_SIZE = 24;
   localparam int CHART [CHART_SIZE] = '{
      830, 770, 705, 640,
      720, 655, 595, 535,
      645, 585, 525, 465,
      530, 475, 415, 360,
      420, 365, 310, 250,
      310, 255, 200, 145
   };

   typedef struct packed {
      logic                      kind;
      logic [ALT_W-1:0]          altitude;
      logic signed [TEMP_W-1:0]  temperature;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [EVAL_W-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [1:0]                status;
   } rsp_type;

   typedef struct packed {
      logic is_load;
      logic out_of_range;
   } tag_type;

   typedef struct packed {
      tag_type          tag;
      logic [FA_W-1:0]  fa;
      logic [FT_W-1:0]  ft;
      logic             row_odd;
      logic             col_odd;
   } math_op_type;

   function automatic int chart_at(input int idx);
      int v;
      v = 0;
      if (idx >= 0 && idx < CHART_SIZE) v = CHART[idx];
      return v;
   endfunction

   // address bits for one half of a dimension of n grid lines
   function automatic int half_bits(input int n);
      int h;
      h = (n + 1) / 2;
      return (h > 1) ? $clog2(h) : 1;
   endfunction

endpackage

FILE: sv/bti_grid.sv
// Grid store: four banks split by row and column parity, so one cell's
// four corners are read in the same cycle. Reload sweep after reset. Uses bti_pkg.
`timescale 1ns / 1ps

module bti_grid #(
   parameter int ALT_ROWS   = 6,
   parameter int TEMP_COLS  = 4,
   parameter int ENTRY_BITS = 12,
   localparam int RHB = bti_pkg::half_bits(ALT_ROWS),
   localparam int CHB = bti_pkg::half_bits(TEMP_COLS),
   localparam int AW  = RHB + CHB
) (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         busy,
   input  logic                         wr_en,
   input  logic [1:0]                   wr_bank,
   input  logic [AW-1:0]                wr_addr,
   input  logic [ENTRY_BITS-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [3:0][AW-1:0]           rd_addr,
   output logic [3:0][ENTRY_BITS-1:0]   rd_data
);
   import bti_pkg::*;

   localparam int BANK_DEPTH = 1 << AW;

   logic          busy_ff;
   logic [AW-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (&clr_cnt_ff) busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [ENTRY_BITS-1:0] mem_q [BANK_DEPTH];
      logic [ENTRY_BITS-1:0] rd_q_ff;
      logic [ENTRY_BITS-1:0] fill_val;

      always_comb begin
         int row;
         int col;
         row = 2 * int'(clr_cnt_ff[AW-1:CHB]) + (b >> 1);
         col = 2 * int'(clr_cnt_ff[CHB-1:0]) + (b & 1);
         fill_val = '0;
         if (row < ALT_ROWS && col < TEMP_COLS)
            fill_val = ENTRY_BITS'(chart_at(row * TEMP_COLS + col));
      end

      always_ff @(posedge clock) begin
         if (busy_ff) begin
            mem_q[clr_cnt_ff] <= fill_val;
         end else if (wr_en && wr_bank == 2'(b)) begin
            mem_q[wr_addr] <= wr_data;
         end
         if (rd_en) rd_q_ff <= mem_q[rd_addr[b]];
      end

      assign rd_data[b] = rd_q_ff;
   end

`ifndef SYNTH
   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !wr_en)
      else $error("grid write during reload sweep");
   a_sweep_once: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |=> !busy_ff)
      else $error("reload sweep restarted without reset");
   a_sweep_full: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !(&clr_cnt_ff) |=> busy_ff)
      else $error("reload sweep ended early");
`endif

endmodule

FILE: sv/bti_math.sv
// Interpolation arithmetic: weight products, cell products, rounding and
// reciprocal divide by 2500 with saturation. Four stages. Uses bti_pkg.
`timescale 1ns / 1ps

module bti_math #(
   parameter int ENTRY_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  bti_pkg::math_op_type        in_op,
   input  logic [3:0][ENTRY_BITS-1:0]  in_bank,
   output logic                        out_valid,
   input  logic                        out_ready,
   output bti_pkg::rsp_type            out_rsp
);
   import bti_pkg::*;

   localparam int P_W = ENTRY_BITS + 5;
   localparam int N_W = ENTRY_BITS + 16;

   logic c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;
   logic c_en, d_en, e_en, f_en;

   assign f_en     = !f_valid_ff || out_ready;
   assign e_en     = !e_valid_ff || f_en;
   assign d_en     = !d_valid_ff || e_en;
   assign c_en     = !c_valid_ff || d_en;
   assign in_ready = c_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (c_en) c_valid_ff <= in_valid;
         if (d_en) d_valid_ff <= c_valid_ff;
         if (e_en) e_valid_ff <= d_valid_ff;
         if (f_en) f_valid_ff <= e_valid_ff;
      end
   end

   // stage C: blend along temperature
   logic signed [ENTRY_BITS-1:0] f00, f01, f10, f11;
   logic [FT_W-1:0]              wt_lo;
   logic signed [P_W-1:0]        wt_lo_s, wt_hi_s, p0_in, p1_in;
   tag_type                      c_tag_ff;
   logic [FA_W-1:0]              c_fa_ff;
   logic signed [P_W-1:0]        c_p0_ff, c_p1_ff;

   always_comb begin
      f00     = signed'(in_bank[{in_op.row_odd, in_op.col_odd}]);
      f01     = signed'(in_bank[{in_op.row_odd, !in_op.col_odd}]);
      f10     = signed'(in_bank[{!in_op.row_odd, in_op.col_odd}]);
      f11     = signed'(in_bank[{!in_op.row_odd, !in_op.col_odd}]);
      wt_lo   = FT_W'(TEMP_STEP) - in_op.ft;
      wt_lo_s = P_W'(signed'({1'b0, wt_lo}));
      wt_hi_s = P_W'(signed'({1'b0, in_op.ft}));
      p0_in   = P_W'(f00) * wt_lo_s + P_W'(f01) * wt_hi_s;
      p1_in   = P_W'(f10) * wt_lo_s + P_W'(f11) * wt_hi_s;
   end

   always_ff @(posedge clock) begin
      if (c_en) begin
         c_tag_ff <= in_op.tag;
         c_fa_ff  <= in_op.fa;
         c_p0_ff  <= p0_in;
         c_p1_ff  <= p1_in;
      end
   end

   // stage D: weight along altitude
   logic [FA_W-1:0]       wa_lo;
   logic signed [N_W-1:0] m0_in, m1_in;
   tag_type               d_tag_ff;
   logic signed [N_W-1:0] d_m0_ff, d_m1_ff;

   always_comb begin
      wa_lo = FA_W'(ALT_STEP) - c_fa_ff;
      m0_in = N_W'(c_p0_ff) * N_W'(signed'({1'b0, wa_lo}));
      m1_in = N_W'(c_p1_ff) * N_W'(signed'({1'b0, c_fa_ff}));
   end

   always_ff @(posedge clock) begin
      if (d_en) begin
         d_tag_ff <= c_tag_ff;
         d_m0_ff  <= m0_in;
         d_m1_ff  <= m1_in;
      end
   end

   // stage E: sum, magnitude, round bias, saturation check
   logic signed [N_W-1:0] num;
   logic [N_W-1:0]        mag, mag_b;
   tag_type               e_tag_ff;
   logic                  e_neg_ff, e_sat_ff;
   logic [QIN_W-1:0]      e_n_ff;

   always_comb begin
      num   = d_m0_ff + d_m1_ff;
      mag   = num[N_W-1] ? N_W'(-num) : N_W'(num);
      mag_b = mag + N_W'(ROUND_BIAS);
   end

   always_ff @(posedge clock) begin
      if (e_en) begin
         e_tag_ff <= d_tag_ff;
         e_neg_ff <= num[N_W-1];
         e_sat_ff <= 64'(mag_b) >= SAT_LIMIT;
         e_n_ff   <= QIN_W'(mag_b >> 2);
      end
   end

   // stage F: divide by 625, sign, saturate, build response
   logic [PROD_W-1:0]        prod;
   logic [QOUT_W-1:0]        quot;
   logic signed [VALUE_W-1:0] val_in;
   rsp_type                  rsp_in;
   rsp_type                  f_rsp_ff;

   always_comb begin
      prod = PROD_W'(e_n_ff) * PROD_W'(QDIV_RECIP);
      quot = prod[QDIV_SHIFT +: QOUT_W];
      priority if (e_sat_ff && e_neg_ff) begin
         val_in = {1'b1, {(VALUE_W-1){1'b0}}};
      end else if (e_sat_ff) begin
         val_in = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (e_neg_ff) begin
         val_in = -signed'({1'b0, quot});
      end else begin
         val_in = signed'({1'b0, quot});
      end
      priority if (e_tag_ff.is_load) begin
         rsp_in.value  = '0;
         rsp_in.status = STATUS_LOADED;
      end else if (e_tag_ff.out_of_range) begin
         rsp_in.value  = '0;
         rsp_in.status = STATUS_RANGE;
      end else begin
         rsp_in.value  = val_in;
         rsp_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) f_rsp_ff <= rsp_in;
   end

   assign out_valid = f_valid_ff;
   assign out_rsp   = f_rsp_ff;

endmodule

FILE: sv/bilinear_table_interpolator_top.sv
// Top level of the bilinear table interpolator: query decode, grid access
// and the arithmetic pipeline. Depends on bti_pkg, bti_grid and bti_math.
//
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_ready   bti_pkg::req_type (query or grid load)
// rsp      out  rsp_valid/rsp_ready   bti_pkg::rsp_type (value, status)
//
// One transaction per cycle while rsp_ready is high and the grid is not reloading;
// a result passes through six register stages: decode, grid read, two
// product stages, rounding, reciprocal divide.
// After reset the grid reloads its chart one bank row per cycle, over
// 2^(half_bits(ALT_ROWS)+half_bits(TEMP_COLS)) bank rows, 8 at the defaults,
// with req_ready low. Each stage holds while the next is full and stalled.
`timescale 1ns / 1ps

module bilinear_table_interpolator_top #(
   parameter int ALT_ROWS   = 6,
   parameter int TEMP_COLS  = 4,
   parameter int ENTRY_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bti_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bti_pkg::rsp_type  rsp_data
);
   import bti_pkg::*;

   localparam int RHB       = half_bits(ALT_ROWS);
   localparam int CHB       = half_bits(TEMP_COLS);
   localparam int AW        = RHB + CHB;
   localparam int ALT_SPAN  = ALT_STEP * (ALT_ROWS - 1);
   localparam int TEMP_SPAN = TEMP_STEP * (TEMP_COLS - 1);

   logic grid_busy;
   logic math_ready;
   logic a_en, b_en, accept;

   // stage A: decode
   logic signed [TEMP_W:0] tmp9;
   logic [TEMP_W-1:0]      tmp8;
   logic [CELL_W-1:0]      row_raw, col_raw;
   logic [INDEX_W-1:0]     ld_row, ld_col;
   logic                   ld_ok;
   tag_type                tag_in;

   always_comb begin
      tmp9    = (TEMP_W+1)'(req_data.temperature) - (TEMP_W+1)'(TEMP_BASE);
      tmp8    = tmp9[TEMP_W-1:0];
      row_raw = CELL_W'((30'(req_data.altitude) * 30'(ROW_RECIP)) >> ROW_SHIFT);
      col_raw = CELL_W'((16'(tmp8) * 16'(COL_RECIP)) >> COL_SHIFT);
      tag_in.is_load      = req_data.kind == KIND_LOAD;
      tag_in.out_of_range = int'(req_data.altitude) > ALT_SPAN || tmp9 < 0 ||
                            int'(tmp9) > TEMP_SPAN;
      ld_row = '0;
      for (int r = 1; r < 32; r++) begin
         if (r < ALT_ROWS && r * TEMP_COLS <= int'(req_data.entry_index))
            ld_row = INDEX_W'(r);
      end
      ld_col = INDEX_W'(int'(req_data.entry_index) - int'(ld_row) * TEMP_COLS);
      ld_ok  = int'(req_data.entry_index) < ALT_ROWS * TEMP_COLS;
   end

   logic                  a_valid_ff;
   tag_type               a_tag_ff;
   logic [ALT_W-1:0]      a_alt_ff;
   logic [TEMP_W-1:0]     a_tmp_ff;
   logic [CELL_W-1:0]     a_row_ff, a_col_ff;
   logic                  a_ld_ok_ff;
   logic [INDEX_W-1:0]    a_ld_row_ff, a_ld_col_ff;
   logic [ENTRY_BITS-1:0] a_ld_val_ff;

   assign a_en      = !a_valid_ff || b_en;
   assign req_ready = a_en && !grid_busy;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_tag_ff    <= tag_in;
         a_alt_ff    <= req_data.altitude;
         a_tmp_ff    <= tmp8;
         a_row_ff    <= row_raw;
         a_col_ff    <= col_raw;
         a_ld_ok_ff  <= ld_ok;
         a_ld_row_ff <= ld_row;
         a_ld_col_ff <= ld_col;
         a_ld_val_ff <= ENTRY_BITS'(req_data.entry_value);
      end
   end

   // stage B: clamp cell, fractions, grid access
   logic [CELL_W-1:0]       row_c, col_c, row_p, col_p;
   logic [ALT_W-1:0]        alt_base, fa_full;
   logic [TEMP_W-1:0]       tmp_base, ft_full;
   logic [3:0][AW-1:0]      rd_addr;
   logic                    wr_en;
   logic [1:0]              wr_bank;
   logic [AW-1:0]           wr_addr;
   math_op_type             op_in;

   always_comb begin
      row_c = a_row_ff;
      col_c = a_col_ff;
      if (int'(a_row_ff) > ALT_ROWS - 2) row_c = CELL_W'(ALT_ROWS - 2);
      if (int'(a_col_ff) > TEMP_COLS - 2) col_c = CELL_W'(TEMP_COLS - 2);
      alt_base = ALT_W'(row_c) * ALT_W'(ALT_STEP);
      fa_full  = a_alt_ff - alt_base;
      tmp_base = TEMP_W'(col_c) * TEMP_W'(TEMP_STEP);
      ft_full  = a_tmp_ff - tmp_base;
      op_in.tag     = a_tag_ff;
      op_in.fa      = fa_full[FA_W-1:0];
      op_in.ft      = ft_full[FT_W-1:0];
      op_in.row_odd = row_c[0];
      op_in.col_odd = col_c[0];
      for (int b = 0; b < 4; b++) begin
         row_p = (row_c[0] == b[1]) ? row_c : row_c + 1'b1;
         col_p = (col_c[0] == b[0]) ? col_c : col_c + 1'b1;
         rd_addr[b] = {RHB'(row_p >> 1), CHB'(col_p >> 1)};
      end
      wr_en   = b_en && a_valid_ff && a_tag_ff.is_load && a_ld_ok_ff;
      wr_bank = {a_ld_row_ff[0], a_ld_col_ff[0]};
      wr_addr = {RHB'(a_ld_row_ff >> 1), CHB'(a_ld_col_ff >> 1)};
   end

   logic                        b_valid_ff;
   math_op_type                 b_op_ff;
   logic [3:0][ENTRY_BITS-1:0]  bank_data;

   assign b_en = !b_valid_ff || math_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) b_op_ff <= op_in;
   end

   bti_grid #(
      .ALT_ROWS   (ALT_ROWS),
      .TEMP_COLS  (TEMP_COLS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_grid (
      .clock   (clock),
      .reset   (reset),
      .busy    (grid_busy),
      .wr_en   (wr_en),
      .wr_bank (wr_bank),
      .wr_addr (wr_addr),
      .wr_data (a_ld_val_ff),
      .rd_en   (b_en),
      .rd_addr (rd_addr),
      .rd_data (bank_data)
   );

   bti_math #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_math (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (math_ready),
      .in_op     (b_op_ff),
      .in_bank   (bank_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_data)
   );

`ifndef SYNTH
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      accept |-> !grid_busy)
      else $error("transaction taken during grid reload");
   a_decode_holds: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_en |=> a_valid_ff)
      else $error("decode stage dropped a stalled transaction");
   a_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_LOADED ||
                    rsp_data.status == STATUS_RANGE) |-> rsp_data.value == '0)
      else $error("nonzero value on load or range response");
`endif

endmodule

FILE: tb/bilinear_table_interpolator_top_tb.sv
// Testbench for bilinear_table_interpolator_top: grid point, range, load and rounding
// checks, then random mixed traffic under random stalls on both channels and a long response stall.
// Depends on bti_pkg and the RTL of the interpolator.
`timescale 1ns / 1ps

module bilinear_table_interpolator_top_tb;
   import bti_pkg::*;

   localparam int ALT_ROWS   = 6;
   localparam int TEMP_COLS  = 4;
   localparam int ENTRY_BITS = 12;
   localparam int GRID_CELLS = ALT_ROWS * TEMP_COLS;
   localparam int ALT_MAX    = ALT_STEP * (ALT_ROWS - 1);
   localparam int TEMP_MAX   = TEMP_BASE + TEMP_STEP * (TEMP_COLS - 1);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic signed [ENTRY_BITS-1:0] model_grid [GRID_CELLS];
   rsp_type expected_rsp_q [$];
   int      mismatch_count = 0;
   bit      req_steady = 1'b0;
   bit      rsp_steady = 1'b0;
   int      hold_cycles = 0;

   bilinear_table_interpolator_top #(
      .ALT_ROWS  (ALT_ROWS),
      .TEMP_COLS (TEMP_COLS),
      .ENTRY_BITS(ENTRY_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // Update the grid copy for loads and compute the interpolated value or range status for queries.
   function automatic rsp_type predict_interpolation(input req_type item);
      rsp_type r;
      longint  alt, tmp, row, col, fa, ft, f00, f01, f10, f11, num, q;
      r = '0;
      if (item.kind == KIND_LOAD) begin
         if (item.entry_index < GRID_CELLS) begin
            model_grid[item.entry_index] = item.entry_value;
         end
         r.status = STATUS_LOADED;
      end else begin
         alt = longint'(item.altitude);
         tmp = longint'($signed(item.temperature)) - TEMP_BASE;
         if (alt > ALT_MAX || tmp < 0 || tmp > TEMP_STEP * (TEMP_COLS - 1)) begin
            r.status = STATUS_RANGE;
         end else begin
            row = alt / ALT_STEP;
            col = tmp / TEMP_STEP;
            if (row > ALT_ROWS - 2) row = ALT_ROWS - 2;
            if (col > TEMP_COLS - 2) col = TEMP_COLS - 2;
            fa  = alt - row * ALT_STEP;
            ft  = tmp - col * TEMP_STEP;
            f00 = longint'(model_grid[row * TEMP_COLS + col]);
            f01 = longint'(model_grid[row * TEMP_COLS + col + 1]);
            f10 = longint'(model_grid[(row + 1) * TEMP_COLS + col]);
            f11 = longint'(model_grid[(row + 1) * TEMP_COLS + col + 1]);
            num = (ALT_STEP - fa) * ((TEMP_STEP - ft) * f00 + ft * f01) +
                  fa * ((TEMP_STEP - ft) * f10 + ft * f11);
            if (num >= 0) q = (num + 1250) / 2500;
            else q = -((-num + 1250) / 2500);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            r.value  = q[VALUE_W-1:0];
            r.status = STATUS_OK;
         end
      end
      return r;
   endfunction

   function automatic req_type query_item(input int alt, input int temp);
      req_type item;
      item             = '0;
      item.kind        = KIND_QUERY;
      item.altitude    = alt[ALT_W-1:0];
      item.temperature = temp[TEMP_W-1:0];
      item.entry_index = $urandom();
      item.entry_value = $urandom();
      return item;
   endfunction

   function automatic req_type load_item(input int idx, input int val);
      req_type item;
      item             = '0;
      item.kind        = KIND_LOAD;
      item.altitude    = $urandom();
      item.temperature = $urandom();
      item.entry_index = idx[INDEX_W-1:0];
      item.entry_value = val[EVAL_W-1:0];
      return item;
   endfunction

   function automatic req_type make_random_item();
      int pick, alt, temp, val;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         alt  = ($urandom_range(0, 3) == 0) ? ALT_STEP * $urandom_range(0, ALT_ROWS - 1)
                                            : $urandom_range(0, ALT_MAX);
         temp = ($urandom_range(0, 3) == 0) ?
                TEMP_BASE + TEMP_STEP * $urandom_range(0, TEMP_COLS - 1) :
                TEMP_BASE + $urandom_range(0, TEMP_MAX - TEMP_BASE);
         return query_item(alt, temp);
      end else if (pick < 78) begin
         case ($urandom_range(0, 2))
            0: return query_item($urandom_range(ALT_MAX + 1, 16383), $urandom_range(0, 255));
            1: return query_item($urandom_range(0, 16383), TEMP_MAX + $urandom_range(1, 87));
            default: return query_item($urandom_range(0, 16383), $urandom_range(0, 255));
         endcase
      end else begin
         case ($urandom_range(0, 7))
            0: val = 2047;
            1: val = -2048;
            default: val = $urandom_range(0, 4095);
         endcase
         return load_item($urandom_range(0, 31), val);
      end
   endfunction

   // Offer one transaction after a random gap (none in steady mode) and hold it until accepted.
   task automatic send_transaction(input req_type item);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(predict_interpolation(item));
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_rsp_q.size() > 0) @(negedge clock);
   endtask

   task automatic test_chart_points();
      send_transaction(query_item(0, -20));
      send_transaction(query_item(0, 40));
      send_transaction(query_item(10000, -20));
      send_transaction(query_item(10000, 40));
      send_transaction(query_item(4000, 0));
      send_transaction(query_item(10000, 10));
      send_transaction(query_item(3000, 40));
      send_transaction(query_item(1000, -10));
      send_transaction(query_item(9999, 39));
      wait_for_results();
   endtask

   task automatic test_out_of_range();
      send_transaction(query_item(10001, 0));
      send_transaction(query_item(16383, 0));
      send_transaction(query_item(0, -21));
      send_transaction(query_item(0, 41));
      send_transaction(query_item(5000, -128));
      send_transaction(query_item(5000, 127));
      wait_for_results();
   endtask

   task automatic test_loads_and_rounding();
      send_transaction(load_item(0, 1));
      send_transaction(load_item(1, 0));
      send_transaction(load_item(4, 0));
      send_transaction(load_item(5, 0));
      send_transaction(query_item(1875, -10));
      send_transaction(load_item(0, -1));
      send_transaction(query_item(1875, -10));
      send_transaction(load_item(31, -2048));
      send_transaction(load_item(24, 2047));
      send_transaction(query_item(0, -20));
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 5; chunk++) begin
         req_steady = (chunk == 1) || (chunk == 3);
         rsp_steady = (chunk == 2) || (chunk == 3);
         for (int n = 0; n < 200; n++) begin
            send_transaction(make_random_item());
         end
         wait_for_results();
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   task automatic test_backpressure();
      req_steady  = 1'b1;
      hold_cycles = 80;
      for (int n = 0; n < 50; n++) begin
         send_transaction(make_random_item());
      end
      req_steady = 1'b0;
      wait_for_results();
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         stall = rsp_steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && hold_cycles == 0);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d status %0d",
                                      rsp_data.value, rsp_data.status));
         end else begin
            expected = expected_rsp_q.pop_front();
            if (rsp_data.value !== expected.value) begin
               report_mismatch($sformatf("value %0d, expected %0d",
                                         rsp_data.value, expected.value));
            end
            if (rsp_data.status !== expected.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, expected.status));
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < GRID_CELLS; i++) begin
         model_grid[i] = (i < CHART_SIZE) ? CHART[i][ENTRY_BITS-1:0] : '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_chart_points();
      test_out_of_range();
      test_loads_and_rounding();
      test_random_traffic();
      test_backpressure();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
